/* design/bebd_pkg.sv */
package bebd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 48;
	localparam int LEVEL_W    = 12;
	localparam int LPC_W      = 15;
	localparam int AVC_W      = 15;
	localparam int PCT_W      = 10;
	localparam int GAP_W      = 24;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int Q_SHIFT    = 15;
	// square of a mono or filtered sample is at most 2^30
	localparam int SQ_W       = 31;
	localparam int AVG_W      = 31;
	localparam int THR_W      = AVG_W + PCT_W;
	localparam int STEP_W     = AVG_W + AVC_W;
	localparam int LP_PROD_W  = SAMPLE_W + 1 + LPC_W + 1;
	localparam int PCT_DIV    = 100;
	localparam int SQRT_IN_W  = 32;
	localparam int ROOT_W     = 16;
	localparam int LEVEL_SHIFT = 4;

	localparam logic [LPC_W-1:0] LPC_RESET = LPC_W'(640);
	localparam logic [AVC_W-1:0] AVC_RESET = AVC_W'(328);
	localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(140);
	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(250000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOWPASS_COEFF,
		CFG_AVERAGE_COEFF,
		CFG_BEAT_PERCENT,
		CFG_MIN_GAP_TIME
	} cfg_idx_t;

	typedef struct packed {
		logic [LPC_W-1:0] lowpass_coeff;
		logic [AVC_W-1:0] average_coeff;
		logic [PCT_W-1:0] beat_percent;
		logic [GAP_W-1:0] min_gap_time;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       frame_end;
		logic [TIME_W-1:0]          now_time;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] bass_level;
		logic [LEVEL_W-1:0] loudness_level;
		logic               beat_fired;
		logic [TIME_W-1:0]  last_beat_time;
	} out_item_t;

	typedef enum logic {
		DIV_BASS,
		DIV_MONO
	} div_sel_t;

	typedef enum logic {
		SQ_BASS,
		SQ_MONO
	} sq_sel_t;

	typedef struct packed {
		logic     mul;
		logic     lp_upd;
		logic     bsq;
		logic     bacc;
		logic     div_start;
		div_sel_t div_sel;
		logic     avg_mul;
		logic     avg_upd;
		logic     thr_mul;
		logic     sqrt_start;
		sq_sel_t  sqrt_sel;
		logic     decide;
	} cmd_t;

	typedef struct packed {
		logic frame_close;
		logic div_done;
		logic sqrt_done;
		logic res_pend;
	} status_t;

endpackage

/* design/bebd_div.sv */
module bebd_div #(
	parameter int N = 41,
	parameter int D = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient,
	output logic         done
);

	localparam int CW = $clog2(N + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [D-1:0]  rem_q;
	logic [N-1:0]  quo_q;
	logic [D-1:0]  dvs_q;

	logic [D:0] rem_sh;
	logic [D:0] rem_sub;
	logic       fits;

	// restoring division, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[N-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[D-1:0] : rem_sh[D-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* design/bebd_sqrt.sv */
module bebd_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bebd_pkg::SQRT_IN_W-1:0]  radicand,
	output logic [bebd_pkg::ROOT_W-1:0]     root,
	output logic                            done
);

	localparam int RW = bebd_pkg::ROOT_W;
	localparam int XW = bebd_pkg::SQRT_IN_W;
	localparam int CW = $clog2(RW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [RW:0]   rem_q;
	logic [RW-1:0] root_q;

	logic [RW+2:0] rem_sh;
	logic [RW+2:0] trial;
	logic [RW+2:0] rem_sub;
	logic          fits;

	// digit-by-digit root, one result bit per cycle
	assign rem_sh  = {rem_q, x_q[XW-1:XW-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign fits    = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[XW-3:0], 2'b00};
			rem_q  <= fits ? rem_sub[RW:0] : rem_sh[RW:0];
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

/* design/bebd_ctrl.sv */
module bebd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  bebd_pkg::status_t status,
	output bebd_pkg::cmd_t    cmd,
	output logic              in_ready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LP,
		S_BSQ,
		S_BACC,
		S_DIVB,
		S_DIVM,
		S_AVGM,
		S_AVGU,
		S_THRM,
		S_SQB,
		S_SQM,
		S_DEC,
		S_OUT
	} state_t;

	state_t         state_q;
	bebd_pkg::cmd_t cmd_q;
	logic           ready_q;

	// commands are registered: each one acts in the cycle of the state it leads into
	always_ff @(posedge clk or negedge arst_n) begin : ctrl_seq
		bebd_pkg::cmd_t cmd_n;
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			ready_q <= 1'b1;
		end else begin
			cmd_n = '0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_MUL;
						cmd_n.mul = 1'b1;
						ready_q   <= 1'b0;
					end
				end
				S_MUL: begin
					state_q      <= S_LP;
					cmd_n.lp_upd = 1'b1;
				end
				S_LP: begin
					state_q   <= S_BSQ;
					cmd_n.bsq = 1'b1;
				end
				S_BSQ: begin
					state_q    <= S_BACC;
					cmd_n.bacc = 1'b1;
				end
				S_BACC: begin
					if (status.frame_close) begin
						state_q         <= S_DIVB;
						cmd_n.div_start = 1'b1;
						cmd_n.div_sel   = bebd_pkg::DIV_BASS;
					end else begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_DIVB: begin
					if (status.div_done) begin
						state_q         <= S_DIVM;
						cmd_n.div_start = 1'b1;
						cmd_n.div_sel   = bebd_pkg::DIV_MONO;
					end
				end
				S_DIVM: begin
					if (status.div_done) begin
						state_q       <= S_AVGM;
						cmd_n.avg_mul = 1'b1;
					end
				end
				S_AVGM: begin
					state_q       <= S_AVGU;
					cmd_n.avg_upd = 1'b1;
				end
				S_AVGU: begin
					state_q       <= S_THRM;
					cmd_n.thr_mul = 1'b1;
				end
				S_THRM: begin
					state_q          <= S_SQB;
					cmd_n.sqrt_start = 1'b1;
					cmd_n.sqrt_sel   = bebd_pkg::SQ_BASS;
				end
				S_SQB: begin
					if (status.sqrt_done) begin
						state_q          <= S_SQM;
						cmd_n.sqrt_start = 1'b1;
						cmd_n.sqrt_sel   = bebd_pkg::SQ_MONO;
					end
				end
				S_SQM: begin
					if (status.sqrt_done) begin
						state_q      <= S_DEC;
						cmd_n.decide = 1'b1;
					end
				end
				S_DEC: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					// wait until the datapath has moved the result to the output register
					if (!status.res_pend) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
			cmd_q <= cmd_n;
		end
	end

	assign cmd      = cmd_q;
	assign in_ready = ready_q;

endmodule

/* design/bebd_dp.sv */
module bebd_dp #(
	parameter int MAX_FRAME = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  bebd_pkg::in_item_t  in_item,
	input  bebd_pkg::cfg_t      cfg,
	input  bebd_pkg::cmd_t      cmd,
	output bebd_pkg::status_t   status,
	output logic                out_valid,
	input  logic                out_stall,
	output bebd_pkg::out_item_t out_item
);

	localparam int SW     = bebd_pkg::SAMPLE_W;
	localparam int CNT_W  = $clog2(MAX_FRAME + 1);
	localparam int SUM_W  = bebd_pkg::SQ_W + $clog2(MAX_FRAME);
	localparam int DIV_W  = SUM_W;
	localparam int DVS_W  = CNT_W;
	localparam int AW     = bebd_pkg::AVG_W;
	localparam int QS     = bebd_pkg::Q_SHIFT;

	// sample path
	logic signed [SW-1:0]                    mono_q;
	logic                                    last_q;
	logic [bebd_pkg::TIME_W-1:0]             now_q;
	logic signed [SW-1:0]                    lp_q;
	logic [bebd_pkg::SQ_W-1:0]               mono_sq_s;
	logic signed [bebd_pkg::LP_PROD_W-1:0]   lp_prod_s;
	logic [bebd_pkg::SQ_W-1:0]               bass_sq_s;
	logic [SUM_W-1:0]                        mono_sum_q;
	logic [SUM_W-1:0]                        bass_sum_q;
	logic [CNT_W-1:0]                        count_q;

	// frame path
	logic [AW-1:0]                           inst_q;
	logic [AW-1:0]                           rms_q;
	logic [AW-1:0]                           avg_q;
	logic [bebd_pkg::STEP_W-1:0]             step_s;
	logic                                    avg_up_s;
	logic [bebd_pkg::THR_W-1:0]              thr_prod_s;
	logic [bebd_pkg::LEVEL_W-1:0]            lvl_bass_q;
	logic [bebd_pkg::LEVEL_W-1:0]            lvl_mono_q;
	logic                                    fired_q;
	logic [bebd_pkg::TIME_W-1:0]             beat_time_q;
	logic                                    res_pend_q;
	logic                                    out_valid_q;
	bebd_pkg::out_item_t                     out_q;
	bebd_pkg::div_sel_t                      div_dest_q;
	bebd_pkg::sq_sel_t                       sq_dest_q;

	logic signed [SW:0]                      pair_sum;
	logic signed [SW:0]                      delta;
	logic signed [2*SW-1:0]                  mono_sq_full;
	logic signed [2*SW-1:0]                  lp_sq_full;
	logic                                    inst_gt;
	logic [AW-1:0]                           diff;
	logic [bebd_pkg::THR_W-1:0]              inst_x100;
	logic [bebd_pkg::TIME_W-1:0]             gap;
	logic                                    fire;
	logic                                    out_free;

	logic [DIV_W-1:0]                        div_num;
	logic [DVS_W-1:0]                        div_den;
	logic [DIV_W-1:0]                        div_quo;
	logic                                    div_done;
	logic [bebd_pkg::SQRT_IN_W-1:0]          sq_in;
	logic [bebd_pkg::ROOT_W-1:0]             sq_root;
	logic                                    sq_done;

	assign pair_sum     = {in_item.left_sample[SW-1], in_item.left_sample}
	                    + {in_item.right_sample[SW-1], in_item.right_sample};
	assign delta        = {mono_q[SW-1], mono_q} - {lp_q[SW-1], lp_q};
	assign mono_sq_full = mono_q * mono_q;
	assign lp_sq_full   = lp_q * lp_q;

	assign inst_gt = inst_q > avg_q;
	assign diff    = inst_gt ? (inst_q - avg_q) : (avg_q - inst_q);

	// inst > floor(avg * percent / 100) holds exactly when 100 * inst > avg * percent
	assign inst_x100 = bebd_pkg::THR_W'(inst_q) * bebd_pkg::THR_W'(bebd_pkg::PCT_DIV);

	assign gap  = now_q - beat_time_q;
	assign fire = (avg_q != '0) && (inst_x100 > thr_prod_s)
	           && (gap >= bebd_pkg::TIME_W'(cfg.min_gap_time));

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (cmd.div_sel)
			bebd_pkg::DIV_BASS: begin
				div_num = DIV_W'(bass_sum_q);
				div_den = DVS_W'(count_q);
			end
			default: begin
				div_num = DIV_W'(mono_sum_q);
				div_den = DVS_W'(count_q);
			end
		endcase
	end

	assign sq_in = (cmd.sqrt_sel == bebd_pkg::SQ_BASS) ? bebd_pkg::SQRT_IN_W'(inst_q)
	                                                   : bebd_pkg::SQRT_IN_W'(rms_q);

	bebd_div #(
		.N(DIV_W),
		.D(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	bebd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (sq_in),
		.root     (sq_root),
		.done     (sq_done)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mono_q <= pair_sum[SW:1];
			last_q <= in_item.frame_end;
			now_q  <= in_item.now_time;
		end
		if (cmd.mul) begin
			mono_sq_s <= mono_sq_full[bebd_pkg::SQ_W-1:0];
			lp_prod_s <= delta * $signed({1'b0, cfg.lowpass_coeff});
		end
		if (cmd.bsq) begin
			bass_sq_s <= lp_sq_full[bebd_pkg::SQ_W-1:0];
		end
		if (cmd.div_start) begin
			div_dest_q <= cmd.div_sel;
		end
		if (div_done) begin
			if (div_dest_q == bebd_pkg::DIV_BASS) begin
				inst_q <= div_quo[AW-1:0];
			end else begin
				rms_q  <= div_quo[AW-1:0];
			end
		end
		if (cmd.avg_mul) begin
			step_s   <= diff * cfg.average_coeff;
			avg_up_s <= inst_gt;
		end
		if (cmd.thr_mul) begin
			thr_prod_s <= avg_q * cfg.beat_percent;
		end
		if (cmd.sqrt_start) begin
			sq_dest_q <= cmd.sqrt_sel;
		end
		if (sq_done) begin
			if (sq_dest_q == bebd_pkg::SQ_BASS) begin
				lvl_bass_q <= sq_root[bebd_pkg::ROOT_W-1:bebd_pkg::LEVEL_SHIFT];
			end else begin
				lvl_mono_q <= sq_root[bebd_pkg::ROOT_W-1:bebd_pkg::LEVEL_SHIFT];
			end
		end
		if (cmd.decide) begin
			fired_q <= fire;
		end
		if (res_pend_q && out_free) begin
			out_q.bass_level     <= lvl_bass_q;
			out_q.loudness_level <= lvl_mono_q;
			out_q.beat_fired     <= fired_q;
			out_q.last_beat_time <= beat_time_q;
		end
	end

	// detector state and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q        <= '0;
			mono_sum_q  <= '0;
			bass_sum_q  <= '0;
			count_q     <= '0;
			avg_q       <= '0;
			beat_time_q <= '0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.lp_upd) begin
				// arithmetic shift floors; the filter never leaves the sample range
				lp_q       <= lp_q + lp_prod_s[QS+SW-1:QS];
				mono_sum_q <= mono_sum_q + SUM_W'(mono_sq_s);
				count_q    <= count_q + CNT_W'(1);
			end
			if (cmd.bacc) begin
				bass_sum_q <= bass_sum_q + SUM_W'(bass_sq_s);
			end
			if (cmd.avg_upd) begin
				if (avg_up_s) begin
					avg_q <= avg_q + step_s[bebd_pkg::STEP_W-1:QS];
				end else begin
					avg_q <= avg_q - step_s[bebd_pkg::STEP_W-1:QS];
				end
			end
			if (cmd.decide) begin
				if (fire) begin
					beat_time_q <= now_q;
				end
				mono_sum_q <= '0;
				bass_sum_q <= '0;
				count_q    <= '0;
				res_pend_q <= 1'b1;
			end else if (res_pend_q && out_free) begin
				res_pend_q <= 1'b0;
			end
			if (res_pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.frame_close = last_q || (count_q == CNT_W'(MAX_FRAME));
	assign status.div_done    = div_done;
	assign status.sqrt_done   = sq_done;
	assign status.res_pend    = res_pend_q;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME))
		else $error("frame sample count passed its cap");

	a_decide_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> !res_pend_q)
		else $error("new frame result while previous one still pending");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !res_pend_q && !cmd.div_start && !cmd.sqrt_start && !cmd.lp_upd)
		else $error("sample accepted while frame work in progress");
`endif

endmodule

/* design/bass_energy_beat_detector_core.sv */
// Bass energy beat detector.
// Input channel in_valid/in_stall/in_data carries one stereo sample pair per transaction,
// with frame_end marking the last pair of a frame and now_time in microseconds.
// Output channel out_valid/out_stall/out_data carries one result per closed frame:
// bass and loudness levels, the beat flag and the time of the latest beat.
// A frame also closes by itself once it holds MAX_FRAME pairs.
// Configuration: cfg_we with cfg_index/cfg_data writes one register per cycle;
// the user must write only while the block is idle; the block itself does not enforce this.
// A pair that does not close a frame is handled as one accept and four
// multiply/accumulate steps on the sample datapath; a closing pair adds
// two passes of the bit-serial divider (the two means, with DIV_W 41 at
// MAX_FRAME 1024) and two 16-step square roots. A new pair is accepted
// only once the previous pair has been through these steps.
// The result is written to an output register, so the next pair is accepted
// while a result waits; a stalled receiver only holds the block once a second
// result is ready. Reset loads the default register values and clears the
// filter, the sums, the moving average and the beat time.
module bass_energy_beat_detector_core #(
	parameter int MAX_FRAME = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bebd_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bebd_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [bebd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bebd_pkg::CFG_W-1:0]        cfg_data
);

	bebd_pkg::cfg_t    cfg_q;
	bebd_pkg::cmd_t    cmd;
	bebd_pkg::status_t status;
	logic              in_ready;
	logic              accept;

	assign accept   = in_valid && in_ready;
	assign in_stall = !in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowpass_coeff <= bebd_pkg::LPC_RESET;
			cfg_q.average_coeff <= bebd_pkg::AVC_RESET;
			cfg_q.beat_percent  <= bebd_pkg::PCT_RESET;
			cfg_q.min_gap_time  <= bebd_pkg::GAP_RESET;
		end else if (cfg_we) begin
			unique case (bebd_pkg::cfg_idx_t'(cfg_index))
				bebd_pkg::CFG_LOWPASS_COEFF: cfg_q.lowpass_coeff <= cfg_data[bebd_pkg::LPC_W-1:0];
				bebd_pkg::CFG_AVERAGE_COEFF: cfg_q.average_coeff <= cfg_data[bebd_pkg::AVC_W-1:0];
				bebd_pkg::CFG_BEAT_PERCENT:  cfg_q.beat_percent  <= cfg_data[bebd_pkg::PCT_W-1:0];
				bebd_pkg::CFG_MIN_GAP_TIME:  cfg_q.min_gap_time  <= cfg_data[bebd_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	bebd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	bebd_dp #(
		.MAX_FRAME(MAX_FRAME)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_data),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_data)
	);

endmodule
